[src/b58_pkg.sv]
// Shared constants, types and the digit-to-character map for the base-58 encoder.
// No dependencies; the top module uses it by scoped names.
package b58_pkg;

	// Byte limit of one number and derived widths
	localparam int MAX_BYTES = 32;
	localparam int VAL_AW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);

	// Digit store: enough for the largest number at the top of the byte range
	localparam int DIG_DEPTH = 64;
	localparam int DIG_AW    = $clog2(DIG_DEPTH);
	localparam int DCNT_W    = DIG_AW + 1;

	localparam int RADIX = 58;
	localparam int REM_W = 6;

	// Output characters
	localparam logic [6:0] ONE_CHAR   = 7'h31;
	localparam logic [6:0] ERR_SYMBOL = 7'h00;

	// Controller states, one-hot
	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_PASS   = 10'b00_0000_0010,
		S_FETCH  = 10'b00_0000_0100,
		S_LOAD   = 10'b00_0000_1000,
		S_DIV    = 10'b00_0001_0000,
		S_WB     = 10'b00_0010_0000,
		S_ONES   = 10'b00_0100_0000,
		S_DFETCH = 10'b00_1000_0000,
		S_DOUT   = 10'b01_0000_0000,
		S_ERR    = 10'b10_0000_0000
	} state_t;

	// Base-58 digit to ASCII; the alphabet skips 0, I, O and l
	function automatic logic [6:0] b58_char(input logic [REM_W-1:0] d);
		logic [6:0] dd;
		logic [6:0] c;
		dd = {1'b0, d};
		if (dd < 7'd9)
			c = 7'h31 + dd;
		else if (dd < 7'd17)
			c = 7'h41 + (dd - 7'd9);
		else if (dd < 7'd22)
			c = 7'h4A + (dd - 7'd17);
		else if (dd < 7'd33)
			c = 7'h50 + (dd - 7'd22);
		else if (dd < 7'd44)
			c = 7'h61 + (dd - 7'd33);
		else
			c = 7'h6D + (dd - 7'd44);
		return c;
	endfunction

endpackage

[src/b58_in_if.sv]
// Input channel of the base-58 encoder: one number byte per word.
// Depends on nothing.
interface b58_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source(output valid, output data_byte, output final_byte, input ready);
	modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

[src/b58_out_if.sv]
// Output channel of the base-58 encoder: one ASCII character per word.
// Depends on nothing.
interface b58_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] symbol;
	logic       end_of_text;
	logic       too_long;

	modport source(output valid, output symbol, output end_of_text, output too_long,
		input ready);
	modport sink(input valid, input symbol, input end_of_text, input too_long,
		output ready);
endinterface

[src/b58_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module b58_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/base58_byte_encoder_top.sv]
// Base-58 encoder (standard alphabet) for a big-endian number given bytewise.
// Depends on b58_pkg, b58_in_if, b58_out_if and b58_ram.
//
// Usage:
//   bytes : input words, data_byte plus final_byte, most significant byte first.
//           Up to b58_pkg::MAX_BYTES bytes are stored, one per cycle, while idle.
//   chars : output words, one ASCII character each, end_of_text on the last.
//           Leading zero bytes come out as '1', then base-58 digits MSB first.
//           Too many bytes give one word with too_long and end_of_text set.
// Timing:
//   The final byte starts the conversion and bytes stays not ready until the
//   last character is loaded into the output register. Each pass divides the
//   remaining value by 58 one bit per cycle through a shift register: a setup
//   step, then per remaining byte a RAM read, a load, 8 divide steps and a
//   write back. A 32-byte value needs about 44 passes. Leading '1' characters
//   then leave at one per cycle while the receiver is ready, each digit after
//   a read of the digit store.
// Reset and stalls:
//   arst_n clears the controller and output valid; RAM contents are not reset.
//   A stalled receiver holds the output register and freezes the emit sequence.
module base58_byte_encoder_top (
	input  logic      clk,
	input  logic      arst_n,
	b58_in_if.sink    bytes,
	b58_out_if.source chars
);

	b58_pkg::state_t                 state_q;
	logic [b58_pkg::CNT_W-1:0]       count_q;
	logic [b58_pkg::CNT_W-1:0]       zcnt_q;
	logic [b58_pkg::CNT_W-1:0]       start_q;
	logic [b58_pkg::CNT_W-1:0]       nstart_q;
	logic [b58_pkg::CNT_W-1:0]       idx_q;
	logic                            in_prefix_q;
	logic                            ovf_q;
	logic                            lead_q;
	logic [2:0]                      bit_q;
	logic [b58_pkg::DCNT_W-1:0]      ndig_q;
	logic                            out_valid_q;
	logic [6:0]                      symbol_q;
	logic                            eot_q;
	logic                            err_q;
	logic [7:0]                      sh_q;
	logic [b58_pkg::REM_W-1:0]       rem_q;

	logic                            in_fire;
	logic                            out_free;
	logic                            out_load;
	logic                            finish;
	logic                            room;
	logic                            zero_byte;
	logic [b58_pkg::CNT_W-1:0]       zcnt_d;
	logic [b58_pkg::CNT_W-1:0]       idx_inc;
	logic                            last_byte;
	logic                            q_zero;
	logic [b58_pkg::CNT_W-1:0]       ns_wb;
	logic [6:0]                      div_acc;
	logic                            div_ge;
	logic [6:0]                      div_r;

	logic                            vwe;
	logic [b58_pkg::VAL_AW-1:0]      vwaddr;
	logic [7:0]                      vwdata;
	logic [7:0]                      vrdata;
	logic                            dwe;
	logic [b58_pkg::DIG_AW-1:0]      draddr;
	logic [b58_pkg::REM_W-1:0]       drdata;

	// Handshake
	assign bytes.ready       = (state_q == b58_pkg::S_IDLE);
	assign in_fire           = bytes.valid && bytes.ready;
	assign out_free          = !out_valid_q || chars.ready;
	assign chars.valid       = out_valid_q;
	assign chars.symbol      = symbol_q;
	assign chars.end_of_text = eot_q;
	assign chars.too_long    = err_q;

	// Byte collection
	assign room      = (count_q < b58_pkg::CNT_W'(b58_pkg::MAX_BYTES));
	assign zero_byte = (bytes.data_byte == 8'h00);
	assign zcnt_d    = (room && in_prefix_q && zero_byte) ? zcnt_q + 1'b1 : zcnt_q;

	// Bit-serial divide by 58: shift one dividend bit into the remainder
	assign div_acc = {rem_q, sh_q[7]};
	assign div_ge  = (div_acc >= 7'(b58_pkg::RADIX));
	assign div_r   = div_ge ? div_acc - 7'(b58_pkg::RADIX) : div_acc;

	// Pass bookkeeping at write-back
	assign idx_inc   = idx_q + 1'b1;
	assign last_byte = (idx_inc == count_q);
	assign q_zero    = (sh_q == 8'h00);
	assign ns_wb     = (lead_q && q_zero) ? idx_inc : nstart_q;

	// Emit control
	assign out_load = out_free && (((state_q == b58_pkg::S_ONES) && (zcnt_q != '0))
		|| (state_q == b58_pkg::S_DOUT) || (state_q == b58_pkg::S_ERR));
	assign finish   = out_load && (((state_q == b58_pkg::S_ONES) && (zcnt_q == 1)
		&& (ndig_q == '0)) || ((state_q == b58_pkg::S_DOUT) && (ndig_q == 1))
		|| (state_q == b58_pkg::S_ERR));

	// Value store: input bytes while idle, quotient bytes at write-back
	assign vwe    = (in_fire && room) || (state_q == b58_pkg::S_WB);
	assign vwaddr = (state_q == b58_pkg::S_WB) ? idx_q[b58_pkg::VAL_AW-1:0]
		: count_q[b58_pkg::VAL_AW-1:0];
	assign vwdata = (state_q == b58_pkg::S_WB) ? sh_q : bytes.data_byte;

	b58_ram #(
		.WIDTH(8),
		.DEPTH(b58_pkg::MAX_BYTES)
	) u_value_ram (
		.clk  (clk),
		.we   (vwe),
		.waddr(vwaddr),
		.wdata(vwdata),
		.raddr(idx_q[b58_pkg::VAL_AW-1:0]),
		.rdata(vrdata)
	);

	// Digit store: remainder of each pass, least significant first
	assign dwe    = (state_q == b58_pkg::S_WB) && last_byte;
	assign draddr = b58_pkg::DIG_AW'(ndig_q - 1'b1);

	b58_ram #(
		.WIDTH(b58_pkg::REM_W),
		.DEPTH(b58_pkg::DIG_DEPTH)
	) u_digit_ram (
		.clk  (clk),
		.we   (dwe),
		.waddr(ndig_q[b58_pkg::DIG_AW-1:0]),
		.wdata(rem_q),
		.raddr(draddr),
		.rdata(drdata)
	);

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= b58_pkg::S_IDLE;
			count_q     <= '0;
			zcnt_q      <= '0;
			start_q     <= '0;
			nstart_q    <= '0;
			idx_q       <= '0;
			in_prefix_q <= 1'b1;
			ovf_q       <= 1'b0;
			lead_q      <= 1'b0;
			bit_q       <= '0;
			ndig_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Last word loaded: back to idle with counts, prefix and overflow flags cleared
			if (finish) begin
				state_q     <= b58_pkg::S_IDLE;
				count_q     <= '0;
				zcnt_q      <= '0;
				in_prefix_q <= 1'b1;
				ovf_q       <= 1'b0;
				ndig_q      <= '0;
			end else begin
				unique case (state_q)
					b58_pkg::S_IDLE: begin
						if (in_fire) begin
							if (room) begin
								count_q <= count_q + 1'b1;
								zcnt_q  <= zcnt_d;
								if (!(in_prefix_q && zero_byte)) begin
									in_prefix_q <= 1'b0;
								end
							end else begin
								ovf_q <= 1'b1;
							end
							if (bytes.final_byte) begin
								start_q <= zcnt_d;
								state_q <= (ovf_q || !room) ? b58_pkg::S_ERR
									: b58_pkg::S_PASS;
							end
						end
					end
					b58_pkg::S_PASS: begin
						if (start_q == count_q) begin
							state_q <= b58_pkg::S_ONES;
						end else begin
							idx_q    <= start_q;
							nstart_q <= start_q;
							lead_q   <= 1'b1;
							state_q  <= b58_pkg::S_FETCH;
						end
					end
					b58_pkg::S_FETCH: begin
						state_q <= b58_pkg::S_LOAD;
					end
					b58_pkg::S_LOAD: begin
						bit_q   <= '0;
						state_q <= b58_pkg::S_DIV;
					end
					b58_pkg::S_DIV: begin
						bit_q <= bit_q + 1'b1;
						if (bit_q == 3'd7) begin
							state_q <= b58_pkg::S_WB;
						end
					end
					b58_pkg::S_WB: begin
						lead_q   <= lead_q && q_zero;
						nstart_q <= ns_wb;
						if (last_byte) begin
							ndig_q  <= ndig_q + 1'b1;
							start_q <= ns_wb;
							state_q <= b58_pkg::S_PASS;
						end else begin
							idx_q   <= idx_inc;
							state_q <= b58_pkg::S_FETCH;
						end
					end
					b58_pkg::S_ONES: begin
						if (zcnt_q == '0) begin
							state_q <= b58_pkg::S_DFETCH;
						end else if (out_free) begin
							zcnt_q <= zcnt_q - 1'b1;
						end
					end
					b58_pkg::S_DFETCH: begin
						state_q <= b58_pkg::S_DOUT;
					end
					b58_pkg::S_DOUT: begin
						if (out_free) begin
							ndig_q  <= ndig_q - 1'b1;
							state_q <= b58_pkg::S_DFETCH;
						end
					end
					b58_pkg::S_ERR: begin
						state_q <= b58_pkg::S_ERR;
					end
					default: begin
						state_q <= b58_pkg::S_IDLE;
					end
				endcase
			end

			// Output register valid
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: divider shift register, remainder, output word
	always_ff @(posedge clk) begin
		if (state_q == b58_pkg::S_PASS) begin
			rem_q <= '0;
		end
		if (state_q == b58_pkg::S_LOAD) begin
			sh_q <= vrdata;
		end
		if (state_q == b58_pkg::S_DIV) begin
			rem_q <= div_r[b58_pkg::REM_W-1:0];
			sh_q  <= {sh_q[6:0], div_ge};
		end
		if (out_load) begin
			if (state_q == b58_pkg::S_ONES) begin
				symbol_q <= b58_pkg::ONE_CHAR;
				eot_q    <= (zcnt_q == 1) && (ndig_q == '0);
				err_q    <= 1'b0;
			end else if (state_q == b58_pkg::S_DOUT) begin
				symbol_q <= b58_pkg::b58_char(drdata);
				eot_q    <= (ndig_q == 1);
				err_q    <= 1'b0;
			end else begin
				symbol_q <= b58_pkg::ERR_SYMBOL;
				eot_q    <= 1'b1;
				err_q    <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// Remainder stays a valid base-58 digit through the divide
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == b58_pkg::S_DIV) |-> (rem_q < b58_pkg::REM_W'(b58_pkg::RADIX)))
		else $error("divider remainder out of range");

	// Stored byte count never passes the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= b58_pkg::CNT_W'(b58_pkg::MAX_BYTES))
		else $error("byte count beyond limit");

	// Pass start never runs past the stored bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == b58_pkg::S_PASS) |-> (start_q <= count_q))
		else $error("pass start beyond byte count");

	// An error word is always the last word of its number
	assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.too_long) |-> chars.end_of_text)
		else $error("error word without end of text");
`endif

endmodule
